FILE: rtl/arv_pkg.sv
// Shared types, constants and table functions for the axis-angle vector rotator.
`default_nettype none

package arv_pkg;

  localparam int DATA_W     = 32;
  localparam int COEF_FRAC  = 30;
  localparam int COEF_W     = COEF_FRAC + 2;
  localparam int TRIG_ITER  = 24;
  localparam int ANGLE_FRAC = 16;
  localparam int NUM_REGS   = 4;
  localparam int ADDR_W     = $clog2(NUM_REGS) + 2;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Angle limits in Q16.16 degrees.
  localparam logic [31:0] ANG_FULL    = 32'(360 << ANGLE_FRAC);
  localparam logic [31:0] ANG_HALF    = 32'(180 << ANGLE_FRAC);
  localparam logic [31:0] ANG_QUARTER = 32'(90 << ANGLE_FRAC);

  // Degrees (Q16.16) to radians (Q60), rounded.
  localparam logic [63:0] KDEG =
    (PI_Q60 + (64'd180 << (ANGLE_FRAC - 1))) / (64'd180 << ANGLE_FRAC);
  localparam logic [31:0] KDEG_LO = KDEG[31:0];
  localparam logic [6:0]  KDEG_HI = KDEG[38:32];

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t coef_arr_t [9];

  typedef enum logic [1:0] {
    REG_AXIS_X,
    REG_AXIS_Y,
    REG_AXIS_Z,
    REG_ANGLE
  } reg_idx_t;

  typedef struct packed {
    logic active;
    logic done;
  } rb_stat_t;

  // Arctangent of 2^-i in Q60 radians, summed from the power series.
  function automatic logic signed [63:0] atan_q60(input int unsigned i);
    logic signed [63:0] sum;
    logic [63:0] term;
    sum = '0;
    term = '0;
    if (i == 0) begin
      return 64'(PI_Q60 >> 2);
    end
    for (int unsigned n = 1; n <= 61; n += 2) begin
      if (i * n <= 60) begin
        term = (64'd1 << (60 - i * n)) / 64'(n);
        if (n[1]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/arv_rebuild.sv
// Rotation matrix builder: axis normalization, angle reduction, CORDIC and matrix assembly.
`default_nettype none

module arv_rebuild (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  arv_pkg::data_t    axis_x,
  input  arv_pkg::data_t    axis_y,
  input  arv_pkg::data_t    axis_z,
  input  arv_pkg::data_t    angle_deg,
  output arv_pkg::rb_stat_t stat,
  output arv_pkg::coef_arr_t coef
);
  import arv_pkg::*;

  localparam int CIW = $clog2(TRIG_ITER);
  localparam int SQRT_STEPS = 32;
  localparam int DIV_LAST = COEF_FRAC + 1;

  localparam logic [4:0] OP_SQ_AXIS   = 5'd0;
  localparam logic [4:0] OP_SQ_AXIS_L = 5'd2;
  localparam logic [4:0] OP_SQ_CS     = 5'd3;
  localparam logic [4:0] OP_SQ_CS_L   = 5'd4;
  localparam logic [4:0] OP_UU        = 5'd5;
  localparam logic [4:0] OP_UUT       = 5'd11;
  localparam logic [4:0] OP_US        = 5'd17;
  localparam logic [4:0] OP_LAST      = 5'd19;

  localparam logic [2:0] DIV_AXIS_L = 3'd2;
  localparam logic [2:0] DIV_COS    = 3'd3;
  localparam logic [2:0] DIV_SIN    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_MUL, S_SQRT, S_DIV, S_AMOD, S_AFIX, S_AFOLD,
    S_ZLO, S_ZHI, S_CORDIC, S_CSMAG, S_MAT
  } state_t;

  state_t state;
  logic [5:0] cnt;
  logic ph;
  logic [4:0] mop;
  logic [2:0] didx;
  logic done_q;

  logic [31:0] am [3];
  logic [2:0] sgn;
  logic [31:0] ang_m;
  logic ang_neg;
  logic signed [25:0] rr;
  logic flip;
  logic signed [58:0] zlo;
  logic signed [63:0] cx, cy, cz;
  logic [32:0] cm, sm;
  logic xneg, yneg;
  logic signed [71:0] prod;
  logic [63:0] acc;
  logic [63:0] sq_r;
  logic [32:0] len;
  logic [32:0] dv_r;
  logic [31:0] dv_q;
  logic signed [31:0] u [3];
  logic signed [31:0] cc, ss;
  logic signed [32:0] tt;
  logic signed [35:0] pp [6];
  logic signed [35:0] us [3];

  logic signed [63:0] atan_tab [TRIG_ITER];
  logic [31:0] mag_in [3];
  logic [31:0] big;
  logic signed [35:0] opa, opb;
  logic signed [35:0] qres;
  logic signed [71:0] prod_rnd;
  logic [63:0] bitv, sq_tmp;
  logic [32:0] dnum;
  logic dneg;
  logic [33:0] dr2;
  logic [31:0] dq_fin;
  logic signed [31:0] dval;
  logic [2:0] pidx;
  logic [1:0] uidx;
  logic [31:0] amod_sub;
  logic [31:0] afix_r;
  logic signed [63:0] cdx, cdy, xf, yf;
  logic [63:0] xmag, ymag;

  for (genvar g = 0; g < TRIG_ITER; g++) begin : g_atan
    assign atan_tab[g] = atan_q60(g);
  end

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic coef_t clamp(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return coef_t'(32'h7FFFFFFF);
    end else if (v < -38'sd2147483648) begin
      return coef_t'(32'h80000000);
    end
    return coef_t'(v[31:0]);
  endfunction

  assign mag_in[0] = mag32(axis_x);
  assign mag_in[1] = mag32(axis_y);
  assign mag_in[2] = mag32(axis_z);

  always_comb begin
    big = am[0];
    if (am[1] > big) begin
      big = am[1];
    end
    if (am[2] > big) begin
      big = am[2];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (mop)
      5'd0: begin opa = 36'($signed({1'b0, am[0]})); opb = opa; end
      5'd1: begin opa = 36'($signed({1'b0, am[1]})); opb = opa; end
      5'd2: begin opa = 36'($signed({1'b0, am[2]})); opb = opa; end
      5'd3: begin opa = 36'($signed({1'b0, cm})); opb = opa; end
      5'd4: begin opa = 36'($signed({1'b0, sm})); opb = opa; end
      5'd5: begin opa = 36'(u[0]); opb = 36'(u[0]); end
      5'd6: begin opa = 36'(u[0]); opb = 36'(u[1]); end
      5'd7: begin opa = 36'(u[0]); opb = 36'(u[2]); end
      5'd8: begin opa = 36'(u[1]); opb = 36'(u[1]); end
      5'd9: begin opa = 36'(u[1]); opb = 36'(u[2]); end
      5'd10: begin opa = 36'(u[2]); opb = 36'(u[2]); end
      5'd11: begin opa = pp[0]; opb = 36'(tt); end
      5'd12: begin opa = pp[1]; opb = 36'(tt); end
      5'd13: begin opa = pp[2]; opb = 36'(tt); end
      5'd14: begin opa = pp[3]; opb = 36'(tt); end
      5'd15: begin opa = pp[4]; opb = 36'(tt); end
      5'd16: begin opa = pp[5]; opb = 36'(tt); end
      5'd17: begin opa = 36'(u[0]); opb = 36'(ss); end
      5'd18: begin opa = 36'(u[1]); opb = 36'(ss); end
      5'd19: begin opa = 36'(u[2]); opb = 36'(ss); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign prod_rnd = (prod + 72'sd536870912) >>> COEF_FRAC;
  assign qres = prod_rnd[35:0];
  assign pidx = (mop < OP_UUT) ? 3'(mop - OP_UU) : 3'(mop - OP_UUT);
  assign uidx = 2'(mop - OP_US);

  assign bitv = 64'd1 << (6'd62 - {cnt[4:0], 1'b0});
  assign sq_tmp = sq_r + bitv;

  always_comb begin
    dnum = '0;
    dneg = 1'b0;
    unique case (didx)
      3'd0: begin dnum = {1'b0, am[0]}; dneg = sgn[0]; end
      3'd1: begin dnum = {1'b0, am[1]}; dneg = sgn[1]; end
      3'd2: begin dnum = {1'b0, am[2]}; dneg = sgn[2]; end
      3'd3: begin dnum = cm; dneg = xneg; end
      3'd4: begin dnum = sm; dneg = yneg; end
      default: begin dnum = '0; dneg = 1'b0; end
    endcase
  end

  assign dr2 = {dv_r, 1'b0};
  assign dq_fin = dv_q + {31'd0, (dr2 >= {1'b0, len})};
  always_comb begin
    if (len == '0) begin
      dval = '0;
    end else if (dneg) begin
      dval = -$signed(dq_fin);
    end else begin
      dval = $signed(dq_fin);
    end
  end

  assign amod_sub = ANG_FULL << (3'd7 - cnt[2:0]);
  assign afix_r = (ang_neg && ang_m != '0) ? (ANG_FULL - ang_m) : ang_m;

  assign cdx = cy >>> cnt[CIW-1:0];
  assign cdy = cx >>> cnt[CIW-1:0];
  assign xf = flip ? -cx : cx;
  assign yf = flip ? -cy : cy;
  assign xmag = xf[63] ? 64'(-xf) : 64'(xf);
  assign ymag = yf[63] ? 64'(-yf) : 64'(yf);

  always_ff @(posedge clk) begin
    done_q <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      ph <= 1'b0;
      mop <= '0;
      didx <= '0;
    end else if (start) begin
      am[0] <= mag_in[0];
      am[1] <= mag_in[1];
      am[2] <= mag_in[2];
      sgn <= {axis_z[DATA_W-1], axis_y[DATA_W-1], axis_x[DATA_W-1]};
      ang_m <= mag32(angle_deg);
      ang_neg <= angle_deg[DATA_W-1];
      acc <= '0;
      mop <= OP_SQ_AXIS;
      ph <= 1'b0;
      cnt <= '0;
      didx <= '0;
      if (mag_in[0] == '0 && mag_in[1] == '0 && mag_in[2] == '0) begin
        for (int k = 0; k < 9; k++) begin
          coef[k] <= '0;
        end
        done_q <= 1'b1;
        state <= S_IDLE;
      end else begin
        state <= S_NORM;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
        end
        S_NORM: begin
          // Bring the largest magnitude to a bit length of exactly 31.
          if (big[31]) begin
            for (int k = 0; k < 3; k++) begin
              am[k] <= am[k] >> 1;
            end
            state <= S_MUL;
          end else if (big[30]) begin
            state <= S_MUL;
          end else begin
            for (int k = 0; k < 3; k++) begin
              am[k] <= am[k] << 1;
            end
          end
        end
        S_MUL: begin
          if (!ph) begin
            prod <= opa * opb;
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (mop <= OP_SQ_CS_L) begin
              acc <= acc + prod[63:0];
            end else if (mop < OP_US) begin
              pp[pidx] <= qres;
            end else begin
              us[uidx] <= qres;
            end
            if (mop == OP_SQ_AXIS_L || mop == OP_SQ_CS_L) begin
              state <= S_SQRT;
              cnt <= '0;
              sq_r <= '0;
            end else if (mop == OP_LAST) begin
              state <= S_MAT;
            end else begin
              mop <= mop + 5'd1;
            end
          end
        end
        S_SQRT: begin
          if (cnt < 6'(SQRT_STEPS)) begin
            if (acc >= sq_tmp) begin
              acc <= acc - sq_tmp;
              sq_r <= (sq_r >> 1) + bitv;
            end else begin
              sq_r <= sq_r >> 1;
            end
            cnt <= cnt + 6'd1;
          end else begin
            len <= sq_r[32:0] + {32'd0, (acc > sq_r)};
            cnt <= '0;
            didx <= (mop == OP_SQ_CS_L) ? DIV_COS : 3'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            if (dnum >= len) begin
              dv_r <= dnum - len;
              dv_q <= 32'd1;
            end else begin
              dv_r <= dnum;
              dv_q <= '0;
            end
            cnt <= cnt + 6'd1;
          end else if (cnt < 6'(DIV_LAST)) begin
            if (dr2 >= {1'b0, len}) begin
              dv_r <= 33'(dr2 - {1'b0, len});
              dv_q <= {dv_q[30:0], 1'b1};
            end else begin
              dv_r <= dr2[32:0];
              dv_q <= {dv_q[30:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
          end else begin
            cnt <= '0;
            unique case (didx)
              3'd0: u[0] <= dval;
              3'd1: u[1] <= dval;
              3'd2: u[2] <= dval;
              3'd3: cc <= dval;
              3'd4: ss <= dval;
              default: begin
              end
            endcase
            if (didx == DIV_AXIS_L) begin
              state <= S_AMOD;
            end else if (didx == DIV_SIN) begin
              tt <= 33'sd1073741824 - 33'(cc);
              mop <= OP_UU;
              ph <= 1'b0;
              state <= S_MUL;
            end else begin
              didx <= didx + 3'd1;
            end
          end
        end
        S_AMOD: begin
          // Remainder of the angle magnitude by a full turn, one binary step per cycle.
          if (ang_m >= amod_sub) begin
            ang_m <= ang_m - amod_sub;
          end
          if (cnt[2:0] == 3'd7) begin
            cnt <= '0;
            state <= S_AFIX;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_AFIX: begin
          if (afix_r >= ANG_HALF) begin
            rr <= 26'($signed(afix_r) - $signed(ANG_FULL));
          end else begin
            rr <= 26'($signed(afix_r));
          end
          state <= S_AFOLD;
        end
        S_AFOLD: begin
          // Fold into a quarter turn; a half-turn step negates sine and cosine.
          if (rr > $signed(26'(ANG_QUARTER))) begin
            rr <= rr - $signed(26'(ANG_HALF));
            flip <= 1'b1;
          end else if (rr < -$signed(26'(ANG_QUARTER))) begin
            rr <= rr + $signed(26'(ANG_HALF));
            flip <= 1'b1;
          end else begin
            flip <= 1'b0;
          end
          state <= S_ZLO;
        end
        S_ZLO: begin
          zlo <= rr * $signed({1'b0, KDEG_LO});
          state <= S_ZHI;
        end
        S_ZHI: begin
          cz <= 64'(zlo) + (64'(34'(rr) * $signed({27'd0, KDEG_HI})) <<< 32);
          cx <= 64'sd1 <<< 59;
          cy <= '0;
          cnt <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!cz[63]) begin
            cx <= cx - cdx;
            cy <= cy + cdy;
            cz <= cz - atan_tab[cnt[CIW-1:0]];
          end else begin
            cx <= cx + cdx;
            cy <= cy - cdy;
            cz <= cz + atan_tab[cnt[CIW-1:0]];
          end
          if (cnt == 6'(TRIG_ITER - 1)) begin
            state <= S_CSMAG;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_CSMAG: begin
          cm <= 33'(xmag >> 29);
          sm <= 33'(ymag >> 29);
          xneg <= xf[63];
          yneg <= yf[63];
          acc <= '0;
          mop <= OP_SQ_CS;
          ph <= 1'b0;
          state <= S_MUL;
        end
        S_MAT: begin
          coef[0] <= clamp(38'(cc) + 38'(pp[0]));
          coef[1] <= clamp(38'(pp[1]) - 38'(us[2]));
          coef[2] <= clamp(38'(pp[2]) + 38'(us[1]));
          coef[3] <= clamp(38'(pp[1]) + 38'(us[2]));
          coef[4] <= clamp(38'(cc) + 38'(pp[3]));
          coef[5] <= clamp(38'(pp[4]) - 38'(us[0]));
          coef[6] <= clamp(38'(pp[2]) - 38'(us[1]));
          coef[7] <= clamp(38'(pp[4]) + 38'(us[0]));
          coef[8] <= clamp(38'(cc) + 38'(pp[5]));
          done_q <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.active = (state != S_IDLE);
  assign stat.done = done_q;

endmodule

`default_nettype wire

FILE: rtl/axis_angle_vector_rotator.sv
// Top level of the axis-angle vector rotator: register port, matrix control and vector pipeline.
`default_nettype none

// Rotates 3D Q16.16 vectors by the matrix built from the programmed axis and angle.
// A request is taken on any cycle where start is high and busy is low, one per clock;
// it passes the input register, the product register and the row-sum register, and its
// result is registered on the ports with the done strobe; the receiver cannot stall.
// After reset and after every register write, busy stays high while the matrix is
// rebuilt with the bit-serial square root (run twice), the fractional divider (run five
// times), the 24-step CORDIC unit and the axis normalization shift.
// A zero axis raises axis_error with zero output.
module axis_angle_vector_rotator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [arv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  arv_pkg::data_t             vec_x,
  input  arv_pkg::data_t             vec_y,
  input  arv_pkg::data_t             vec_z,
  output logic                       done,
  output arv_pkg::data_t             rot_x,
  output arv_pkg::data_t             rot_y,
  output arv_pkg::data_t             rot_z,
  output logic                       axis_error,
  output logic                       overflow
);
  import arv_pkg::*;

  data_t axis_x, axis_y, axis_z, angle_deg;
  logic matrix_current;
  logic pend;
  logic cfg_wr;
  reg_idx_t cfg_idx;
  rb_stat_t rb_stat;
  coef_arr_t coef;
  logic axis_zero;

  logic s0_valid, s1_valid, s2_valid;
  logic s0_err, s1_err, s2_err;
  data_t s0_v [3];
  logic signed [63:0] s1_prod [9];
  logic signed [35:0] s2_acc [3];
  logic signed [65:0] row_sum [3];
  data_t sat_val [3];
  logic [2:0] sat_ovf;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_AXIS_X: prdata = axis_x;
      REG_AXIS_Y: prdata = axis_y;
      REG_AXIS_Z: prdata = axis_z;
      REG_ANGLE:  prdata = angle_deg;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x <= '0;
      axis_y <= '0;
      axis_z <= data_t'(32'h0001_0000);
      angle_deg <= '0;
      matrix_current <= 1'b0;
      pend <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_AXIS_X: axis_x <= pwdata;
        REG_AXIS_Y: axis_y <= pwdata;
        REG_AXIS_Z: axis_z <= pwdata;
        REG_ANGLE:  angle_deg <= pwdata;
        default: begin
        end
      endcase
      matrix_current <= 1'b0;
      pend <= 1'b1;
    end else begin
      pend <= 1'b0;
      // A finish that lands as a restart is issued belongs to the stale run.
      if (rb_stat.done && !pend) begin
        matrix_current <= 1'b1;
      end
    end
  end

  arv_rebuild u_rebuild (
    .clk       (clk),
    .rst       (rst),
    .start     (pend),
    .axis_x    (axis_x),
    .axis_y    (axis_y),
    .axis_z    (axis_z),
    .angle_deg (angle_deg),
    .stat      (rb_stat),
    .coef      (coef)
  );

  assign busy = !matrix_current;
  assign axis_zero = (axis_x == '0) && (axis_y == '0) && (axis_z == '0);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = 66'(s1_prod[3*r]) + 66'(s1_prod[3*r+1]) + 66'(s1_prod[3*r+2])
                   + 66'sd536870912;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (s2_acc[r] > 36'sd2147483647) begin
        sat_val[r] = data_t'(32'h7FFFFFFF);
        sat_ovf[r] = 1'b1;
      end else if (s2_acc[r] < -36'sd2147483648) begin
        sat_val[r] = data_t'(32'h80000000);
        sat_ovf[r] = 1'b1;
      end else begin
        sat_val[r] = s2_acc[r][31:0];
        sat_ovf[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      done <= s2_valid;
    end
    s0_v[0] <= vec_x;
    s0_v[1] <= vec_y;
    s0_v[2] <= vec_z;
    s0_err <= axis_zero;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        s1_prod[3*r+j] <= coef[3*r+j] * s0_v[j];
      end
    end
    s1_err <= s0_err;
    for (int r = 0; r < 3; r++) begin
      s2_acc[r] <= row_sum[r][65:30];
    end
    s2_err <= s1_err;
    if (s2_err) begin
      rot_x <= '0;
      rot_y <= '0;
      rot_z <= '0;
      overflow <= 1'b0;
    end else begin
      rot_x <= sat_val[0];
      rot_y <= sat_val[1];
      rot_z <= sat_val[2];
      overflow <= |sat_ovf;
    end
    axis_error <= s2_err;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted request did not produce a result on time");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && axis_error) |-> (rot_x == '0 && rot_y == '0 && rot_z == '0 && !overflow))
    else $error("zero axis result is not zero");

  a_rebuild_busy: assert property (@(posedge clk) disable iff (rst)
    rb_stat.active |-> busy)
    else $error("matrix rebuild running while requests are accepted");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    $rose(matrix_current) |-> (!s0_valid && !s1_valid && !s2_valid))
    else $error("matrix changed under requests in flight");
`endif

endmodule

`default_nettype wire

FILE: tb/arv_checker.sv
// Checker for the axis-angle vector rotator: tracks register writes, predicts results, compares.
`default_nettype none

module arv_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [arv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  input  logic                       start,
  input  logic                       busy,
  input  arv_pkg::data_t             vec_x,
  input  arv_pkg::data_t             vec_y,
  input  arv_pkg::data_t             vec_z,
  input  logic                       done,
  input  arv_pkg::data_t             rot_x,
  input  arv_pkg::data_t             rot_y,
  input  arv_pkg::data_t             rot_z,
  input  logic                       axis_error,
  input  logic                       overflow,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import arv_pkg::*;

  typedef struct {
    data_t x, y, z;
    logic  err, ovf;
  } rot_result_t;

  localparam logic [63:0] PI_FX = 64'h3243F6A8885A308D;

  rot_result_t rot_expected[$];
  data_t  axis_reg [3];
  data_t  angle_reg;
  longint coef [9];
  bit     matrix_ok;

  function automatic logic [63:0] root_rnd(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v > r) r = r + 1;
    return r;
  endfunction

  // Rounded num/den with COEF_FRAC fraction bits, sign applied afterwards.
  function automatic longint unit_frac(logic [63:0] num, logic [63:0] den, bit neg);
    logic [63:0] q, r;
    q = '0;
    r = num;
    if (den == 0) return 0;
    if (r >= den) begin
      q = 1;
      r = r - den;
    end
    for (int i = 0; i < COEF_FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    if (2 * r >= den) q = q + 1;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint arctan_fx(int i);
    longint acc;
    logic [63:0] term;
    acc = 0;
    if (i == 0) return longint'(PI_FX >> 2);
    for (int n = 1; i * n <= 60; n += 2) begin
      term = (64'd1 << (60 - i * n)) / n;
      if ((n >> 1) % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return acc;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = pa * pb;
    p = (p + (128'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    return longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  task automatic rebuild_matrix();
    logic [63:0] am [3];
    logic [63:0] big, len, cm, sm, kdeg;
    longint u [3];
    longint r, z, x, y, c, s, t, dx, dy, lim;
    int bl;
    bit flip;
    big = 0;
    bl = 0;
    flip = 0;
    lim = longint'(1) << (COEF_FRAC + 1);
    kdeg = (PI_FX + (64'd180 << (ANGLE_FRAC - 1))) / (64'd180 << ANGLE_FRAC);
    for (int i = 0; i < 3; i++) begin
      am[i] = magnitude(longint'(axis_reg[i]));
      if (am[i] > big) big = am[i];
    end
    if (big == 0) begin
      foreach (coef[i]) coef[i] = 0;
      return;
    end
    while (big != 0) begin
      bl++;
      big = big >> 1;
    end
    for (int i = 0; i < 3; i++)
      am[i] = bl > 31 ? am[i] >> (bl - 31) : am[i] << (31 - bl);
    len = root_rnd(am[0] * am[0] + am[1] * am[1] + am[2] * am[2]);
    for (int i = 0; i < 3; i++) u[i] = unit_frac(am[i], len, axis_reg[i] < 0);

    // Reduce to [-180,180), then fold into [-90,90]; the fold negates sine and cosine.
    r = longint'(angle_reg) % (longint'(360) << ANGLE_FRAC);
    if (r < 0) r = r + (longint'(360) << ANGLE_FRAC);
    if (r >= (longint'(180) << ANGLE_FRAC)) r = r - (longint'(360) << ANGLE_FRAC);
    if (r > (longint'(90) << ANGLE_FRAC)) begin
      r = r - (longint'(180) << ANGLE_FRAC);
      flip = 1;
    end else if (r < -(longint'(90) << ANGLE_FRAC)) begin
      r = r + (longint'(180) << ANGLE_FRAC);
      flip = 1;
    end
    z = r * longint'(kdeg);
    x = longint'(1) << 59;
    y = 0;
    for (int i = 0; i < TRIG_ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_fx(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_fx(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cm = magnitude(x) >> 29;
    sm = magnitude(y) >> 29;
    len = root_rnd(cm * cm + sm * sm);
    c = unit_frac(cm, len, x < 0);
    s = unit_frac(sm, len, y < 0);
    t = (longint'(1) << COEF_FRAC) - c;

    coef[0] = c + fx_mul(fx_mul(u[0], u[0]), t);
    coef[1] = fx_mul(fx_mul(u[0], u[1]), t) - fx_mul(u[2], s);
    coef[2] = fx_mul(fx_mul(u[0], u[2]), t) + fx_mul(u[1], s);
    coef[3] = fx_mul(fx_mul(u[1], u[0]), t) + fx_mul(u[2], s);
    coef[4] = c + fx_mul(fx_mul(u[1], u[1]), t);
    coef[5] = fx_mul(fx_mul(u[1], u[2]), t) - fx_mul(u[0], s);
    coef[6] = fx_mul(fx_mul(u[2], u[0]), t) - fx_mul(u[1], s);
    coef[7] = fx_mul(fx_mul(u[2], u[1]), t) + fx_mul(u[0], s);
    coef[8] = c + fx_mul(fx_mul(u[2], u[2]), t);
    foreach (coef[i]) begin
      if (coef[i] > lim - 1) coef[i] = lim - 1;
      if (coef[i] < -lim) coef[i] = -lim;
    end
  endtask

  task automatic predict_rotation(data_t vx, data_t vy, data_t vz);
    rot_result_t res;
    logic signed [127:0] acc, cf, vv;
    data_t comp [3];
    data_t v [3];
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    res.ovf = 0;
    if (!matrix_ok) begin
      rebuild_matrix();
      matrix_ok = 1;
    end
    if (axis_reg[0] == 0 && axis_reg[1] == 0 && axis_reg[2] == 0) begin
      res = '{x: '0, y: '0, z: '0, err: 1'b1, ovf: 1'b0};
      rot_expected.push_back(res);
      return;
    end
    for (int row = 0; row < 3; row++) begin
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        cf = coef[row * 3 + j];
        vv = v[j];
        acc = acc + cf * vv;
      end
      acc = (acc + (128'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (acc > 128'sd2147483647) begin
        comp[row] = 32'h7FFFFFFF;
        res.ovf = 1;
      end else if (acc < -128'sd2147483648) begin
        comp[row] = 32'h80000000;
        res.ovf = 1;
      end else begin
        comp[row] = acc[31:0];
      end
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    res.err = 0;
    rot_expected.push_back(res);
  endtask

  assign pending = rot_expected.size();

  always @(posedge clk) begin
    rot_result_t want;
    if (rst) begin
      axis_reg[0] = '0;
      axis_reg[1] = '0;
      axis_reg[2] = 32'sd65536;
      angle_reg = '0;
      foreach (coef[i]) coef[i] = (i % 4 == 0) ? (longint'(1) << COEF_FRAC) : 0;
      matrix_ok = 0;
      rot_expected.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_AXIS_X: axis_reg[0] = pwdata;
          REG_AXIS_Y: axis_reg[1] = pwdata;
          REG_AXIS_Z: axis_reg[2] = pwdata;
          REG_ANGLE:  angle_reg = pwdata;
        endcase
        matrix_ok = 0;
      end
      if (start && !busy) predict_rotation(vec_x, vec_y, vec_z);
      if (done) begin
        if (rot_expected.size() == 0) begin
          if (errors < 10) $display("unexpected rotated vector %h %h %h", rot_x, rot_y, rot_z);
          errors <= errors + 1;
        end else begin
          want = rot_expected.pop_front();
          if (rot_x !== want.x || rot_y !== want.y || rot_z !== want.z ||
              axis_error !== want.err || overflow !== want.ovf) begin
            if (errors < 10)
              $display("rotation wrong: expected %h %h %h err=%b ovf=%b, got %h %h %h err=%b ovf=%b",
                       want.x, want.y, want.z, want.err, want.ovf,
                       rot_x, rot_y, rot_z, axis_error, overflow);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_axis_angle_vector_rotator.sv
// Top of the rotator testbench: clock, reset, register programming and vector requests.
`default_nettype none

module tb_axis_angle_vector_rotator;
  timeunit 1ns;
  timeprecision 1ps;
  import arv_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready, start = 0, busy, done, axis_error, overflow;
  data_t vec_x = '0, vec_y = '0, vec_z = '0;
  data_t rot_x, rot_y, rot_z;
  int errors, pending, quiet_cycles;
  int idle_pct;

  always #2 clk = ~clk;

  axis_angle_vector_rotator u_top (.*);

  arv_checker u_check (.*);

  // Watchdog: a quiet stretch much longer than a rebuild ends the run as a mismatch.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("axis_angle_vector_rotator: mismatch");
      $finish;
    end
  end

  task automatic send_vector(data_t x, data_t y, data_t z);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    start <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_rotation(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                              logic [31:0] ang);
    write_reg(REG_AXIS_X, ax);
    write_reg(REG_AXIS_Y, ay);
    write_reg(REG_AXIS_Z, az);
    write_reg(REG_ANGLE, ang);
  endtask

  function automatic data_t random_component();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $signed(32'($urandom_range(20'hFFFFF))) - 32'sh80000;
      2: return $signed(32'($urandom_range(8'hFF))) - 32'sh80;
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  task automatic directed_vectors();
    send_vector(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_vector(32'h80000000, 32'h80000000, 32'h80000000);
    send_vector(32'h7FFFFFFF, 32'h80000000, 32'h0);
    send_vector(0, 0, 0);
    send_vector(32'hFFFFFFFF, 1, 32'h00010000);
    send_vector(32'h00010000, 32'hFFFF0000, 32'h00008000);
  endtask

  initial begin
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Reset matrix, then axis and angle extremes and a zero axis; the tiny axis set last gets no vectors.
    directed_vectors();
    set_rotation(0, 0, 32'h00010000, 32'(90 << 16));
    directed_vectors();
    set_rotation(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    directed_vectors();
    set_rotation(32'h7FFFFFFF, 0, 1, 32'h80000000);
    directed_vectors();
    set_rotation(0, 0, 0, 32'(45 << 16));
    directed_vectors();
    set_rotation(1, 0, 0, 32'(-180 << 16));

    for (int ph = 0; ph < 14; ph++) begin
      // The receiver cannot stall, so only the sender idles.
      idle_pct = (ph % 4 == 1) ? 79 : (ph % 4 == 3 ? 26 : 0);
      case (ph % 3)
        0: set_rotation($urandom(), $urandom(), $urandom(), $urandom());
        1: set_rotation(random_component(), random_component(), random_component(),
                        32'($urandom_range(8) * 45 - 180) << 16);
        default: set_rotation(random_component(), random_component(), random_component(),
                              32'($signed($urandom_range(32'h02D00000)) - 32'sh01680000));
      endcase
      for (int n = 0; n < 130; n++) begin
        if ($urandom_range(2) == 0) send_vector($urandom(), $urandom(), $urandom());
        else send_vector(random_component(), random_component(), random_component());
      end
    end
    start <= 0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("axis_angle_vector_rotator: match");
    end else begin
      $display("axis_angle_vector_rotator: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
